// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the sha-1 stream hasher rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHA_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sha1 hasher assertion failed");

// next-cycle implication
`define SHA_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sha1 hasher assertion failed");

`endif

// ===== rtl/sha1bsh_pkg.sv =====
// ---------------------------------------------------------------------------
// sha1bsh_pkg
// shared types and constants of the sha-1 byte stream hasher
// ---------------------------------------------------------------------------
`default_nettype none

package sha1bsh_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTRW  = $clog2(QDEPTH);
  localparam int QCNTW  = $clog2(QDEPTH + 1);
  localparam int LENW   = 61;

  typedef logic [7:0]       byte_t;
  typedef logic [31:0]      word_t;
  typedef logic [4:0][31:0] chain_t;
  typedef logic [1:0]       op_t;

  localparam op_t OP_NONE     = 2'd0;
  localparam op_t OP_BYTE     = 2'd1;
  localparam op_t OP_END      = 2'd2;
  localparam op_t OP_BYTE_END = 2'd3;

  typedef struct packed {
    byte_t data;
    op_t   op;
  } item_t;

  typedef struct packed {
    logic  load;
    logic  start;
    word_t word;
  } eng_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  localparam chain_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam byte_t PAD_MARK = 8'h80;

endpackage

`default_nettype wire

// ===== rtl/sha1bsh_front.sv =====
// ---------------------------------------------------------------------------
// sha1bsh_front
// classifies incoming words and drops those that carry nothing
// ---------------------------------------------------------------------------
`default_nettype none

module sha1bsh_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sha1bsh_pkg::byte_t  in_tdata,   // data_byte
  input  logic                in_tuser,   // byte_present
  input  logic                in_tlast,   // end_of_message
  output logic                q_push,
  output sha1bsh_pkg::item_t  q_item,
  input  logic                q_full
);
  import sha1bsh_pkg::*;

  op_t op;

  always_comb begin
    op          = {in_tlast, in_tuser};
    q_item.data = in_tdata;
    q_item.op   = op;
    // empty words are taken at once and never queued
    in_tready   = !q_full || (op == OP_NONE);
    q_push      = in_tvalid && in_tready && (op != OP_NONE);
  end

endmodule

`default_nettype wire

// ===== rtl/sha1bsh_queue.sv =====
// ---------------------------------------------------------------------------
// sha1bsh_queue
// short queue of classified words between front and back
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sha1bsh_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sha1bsh_pkg::item_t item_i,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output sha1bsh_pkg::item_t item_o
);
  import sha1bsh_pkg::*;

  item_t            mem_r [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_r;
  logic [QPTRW-1:0] rd_ptr_r;
  logic [QCNTW-1:0] count_r;

  assign full   = (count_r == QCNTW'(QDEPTH));
  assign valid  = (count_r != '0);
  assign item_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTRW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTRW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNTW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNTW'(1);
      end
    end
  end

  `SHA_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, count_r != '0)
  `SHA_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, !full)
  `SHA_ASSERT_NXT(a_q_count_up, clk, rst_n, push && !pop,
                  count_r == $past(count_r) + QCNTW'(1))

endmodule

`default_nettype wire

// ===== rtl/sha1bsh_engine.sv =====
// ---------------------------------------------------------------------------
// sha1bsh_engine
// sha-1 compression: 16-word schedule window and one round per cycle
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sha1bsh_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha1bsh_pkg::eng_ctl_t  ctl,
  input  sha1bsh_pkg::chain_t    chain_i,
  output sha1bsh_pkg::eng_stat_t stat,
  output sha1bsh_pkg::chain_t    hash_o
);
  import sha1bsh_pkg::*;

  localparam logic [6:0] LAST_ROUND = 7'd79;

  word_t      win_r [16];
  chain_t     abcde_r;
  logic [6:0] cnt_r;
  logic       busy_r;
  logic       done_r;

  word_t w_mix;
  word_t w_new;
  word_t f_val;
  word_t k_val;
  word_t t_sum;
  word_t a_v, b_v, c_v, d_v, e_v;

  always_comb begin
    a_v   = abcde_r[0];
    b_v   = abcde_r[1];
    c_v   = abcde_r[2];
    d_v   = abcde_r[3];
    e_v   = abcde_r[4];
    w_mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    w_new = {w_mix[30:0], w_mix[31]};
    priority if (cnt_r < 7'd20) begin
      f_val = (b_v & c_v) | (~b_v & d_v);
      k_val = K0;
    end else if (cnt_r < 7'd40) begin
      f_val = b_v ^ c_v ^ d_v;
      k_val = K1;
    end else if (cnt_r < 7'd60) begin
      f_val = (b_v & c_v) | (b_v & d_v) | (c_v & d_v);
      k_val = K2;
    end else begin
      f_val = b_v ^ c_v ^ d_v;
      k_val = K3;
    end
    t_sum = {a_v[26:0], a_v[31:27]} + f_val + e_v + k_val + win_r[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load || busy_r) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= ctl.load ? ctl.word : w_new;
    end
    if (ctl.start) begin
      abcde_r <= chain_i;
    end else if (busy_r) begin
      abcde_r <= {d_v, c_v, {b_v[1:0], b_v[31:2]}, a_v, t_sum};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_ROUND) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 7'd1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign hash_o    = abcde_r;

  `SHA_ASSERT_IMP(a_eng_start_idle, clk, rst_n, ctl.start, !busy_r)
  `SHA_ASSERT_IMP(a_eng_load_idle, clk, rst_n, ctl.load, !busy_r)
  `SHA_ASSERT_NXT(a_eng_done_after_last, clk, rst_n,
                  busy_r && (cnt_r == LAST_ROUND), done_r && !busy_r)

endmodule

`default_nettype wire

// ===== rtl/sha1bsh_back.sv =====
// ---------------------------------------------------------------------------
// sha1bsh_back
// byte packing, padding sequencer, chaining words and digest register
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sha1bsh_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  sha1bsh_pkg::item_t     q_item,
  output logic                   q_pop,
  output sha1bsh_pkg::eng_ctl_t  eng_ctl,
  input  sha1bsh_pkg::eng_stat_t eng_stat,
  input  sha1bsh_pkg::chain_t    hash_i,
  output sha1bsh_pkg::chain_t    chain_o,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output sha1bsh_pkg::chain_t    out_tdata
);
  import sha1bsh_pkg::*;

  localparam logic [2:0] ST_ACCEPT   = 3'd0;
  localparam logic [2:0] ST_PAD80    = 3'd1;
  localparam logic [2:0] ST_PADZ     = 3'd2;
  localparam logic [2:0] ST_PADLEN   = 3'd3;
  localparam logic [2:0] ST_COMPRESS = 3'd4;
  localparam logic [2:0] ST_FINISH   = 3'd5;

  localparam logic [5:0] LAST_SLOT = 6'd63;
  localparam logic [5:0] LEN_SLOT  = 6'd56;

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      ret_r, ret_nxt;
  logic [5:0]      fill_r;
  logic [LENW-1:0] len_r;
  logic [23:0]     pack_r;
  chain_t          chain_r;
  chain_t          out_data_r;
  logic            out_valid_r;

  logic        push_en;
  byte_t       push_byte;
  logic        len_inc;
  logic        add_chain;
  logic        finish_load;
  logic        has_byte;
  logic        has_end;
  logic        blk_full;
  logic        out_free;
  logic [63:0] len_bits;
  logic [63:0] len_sh;

  always_comb begin
    has_byte    = (q_item.op == OP_BYTE) || (q_item.op == OP_BYTE_END);
    has_end     = (q_item.op == OP_END) || (q_item.op == OP_BYTE_END);
    blk_full    = (fill_r == LAST_SLOT);
    out_free    = !out_valid_r || out_tready;
    len_bits    = {len_r, 3'b000};
    len_sh      = len_bits >> {3'd7 - fill_r[2:0], 3'b000};
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    push_en     = 1'b0;
    push_byte   = '0;
    len_inc     = 1'b0;
    add_chain   = 1'b0;
    finish_load = 1'b0;
    q_pop       = 1'b0;
    unique case (state_r)
      ST_ACCEPT: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (has_byte) begin
            push_en   = 1'b1;
            push_byte = q_item.data;
            len_inc   = 1'b1;
          end
          if (has_byte && blk_full) begin
            state_nxt = ST_COMPRESS;
            ret_nxt   = has_end ? ST_PAD80 : ST_ACCEPT;
          end else if (has_end) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        push_en   = 1'b1;
        push_byte = PAD_MARK;
        if (blk_full) begin
          state_nxt = ST_COMPRESS;
          ret_nxt   = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (fill_r == LEN_SLOT) begin
          state_nxt = ST_PADLEN;
        end else begin
          push_en = 1'b1;
          if (blk_full) begin
            state_nxt = ST_COMPRESS;
            ret_nxt   = ST_PADZ;
          end
        end
      end
      ST_PADLEN: begin
        push_en   = 1'b1;
        push_byte = len_sh[7:0];
        if (blk_full) begin
          state_nxt = ST_COMPRESS;
          ret_nxt   = ST_FINISH;
        end
      end
      ST_COMPRESS: begin
        if (eng_stat.done) begin
          add_chain = 1'b1;
          state_nxt = ret_r;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          finish_load = 1'b1;
          state_nxt   = ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
    eng_ctl.load  = push_en && (fill_r[1:0] == 2'b11);
    eng_ctl.start = push_en && blk_full;
    eng_ctl.word  = {pack_r, push_byte};
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      pack_r <= {pack_r[15:0], push_byte};
    end
    if (finish_load) begin
      out_data_r <= chain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      ret_r       <= ST_ACCEPT;
      fill_r      <= '0;
      len_r       <= '0;
      chain_r     <= SHA1_IV;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (push_en) begin
        fill_r <= fill_r + 6'd1;
      end
      if (finish_load) begin
        len_r <= '0;
      end else if (len_inc) begin
        len_r <= len_r + LENW'(1);
      end
      if (finish_load) begin
        chain_r <= SHA1_IV;
      end else if (add_chain) begin
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= chain_r[i] + hash_i[i];
        end
      end
      if (finish_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign chain_o    = chain_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SHA_ASSERT_IMP(a_done_in_compress, clk, rst_n, eng_stat.done, state_r == ST_COMPRESS)
  `SHA_ASSERT_IMP(a_busy_in_compress, clk, rst_n, eng_stat.busy, state_r == ST_COMPRESS)
  `SHA_ASSERT_IMP(a_finish_block_empty, clk, rst_n, state_r == ST_FINISH, fill_r == '0)
  `SHA_ASSERT_IMP(a_len_in_tail, clk, rst_n, state_r == ST_PADLEN, fill_r >= LEN_SLOT)

endmodule

`default_nettype wire

// ===== rtl/sha1_byte_stream_hasher_core.sv =====
// ---------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// sha-1 digest of a byte stream, one optional byte per input word
// a 64-byte block is compressed in the single-round compression engine
//   (80 rounds, one chaining add) while byte intake pauses; words without
//   a byte or end mark are always taken and never queued; after the end
//   word, padding goes in one byte per cycle, held while a block is
//   compressed, one or two compressions before the digest word goes out
// reset: rst_n synchronous, loads the initial chaining values, clears counts
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_byte_stream_hasher_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // data_byte
  input  logic         in_tuser,    // byte_present
  input  logic         in_tlast,    // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata    // digest_word0 .. digest_word4
);
  import sha1bsh_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  item_t     q_in;
  item_t     q_out;
  eng_ctl_t  eng_ctl;
  eng_stat_t eng_stat;
  chain_t    hash;
  chain_t    chain;
  chain_t    digest;

  sha1bsh_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_item    (q_in),
    .q_full    (q_full)
  );

  sha1bsh_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .item_i (q_in),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .item_o (q_out)
  );

  sha1bsh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .eng_ctl    (eng_ctl),
    .eng_stat   (eng_stat),
    .hash_i     (hash),
    .chain_o    (chain),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (digest)
  );

  sha1bsh_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (eng_ctl),
    .chain_i (chain),
    .stat    (eng_stat),
    .hash_o  (hash)
  );

  assign out_tdata = digest;

endmodule

`default_nettype wire
